[sv/ecbt_pkg.sv]
// Package with the types, codes and constants shared by the event control block table.
`timescale 1ns / 1ps

package ecbt_pkg;

    localparam int CLASS_GROUPS_DEF    = 6;
    localparam int SLOTS_PER_CLASS_DEF = 32;
    localparam int CLASSES_PER_GROUP   = 32;
    localparam int QUEUE_DEPTH         = 2;
    localparam int EV_W                = 9;
    localparam int SPEC_W              = 8;
    localparam int HANDLER_W           = 32;
    localparam int SLOT_W              = 2 + 2 + HANDLER_W;

    localparam logic [3:0]  GROUP_ALIAS    = 4'hf;
    localparam logic [3:0]  GROUP_ALIASED  = 4'h5;
    localparam logic [15:0] MASK_SPEC16    = 16'h0301;
    localparam logic [15:0] MASK_SPEC17    = 16'h0302;
    localparam logic [7:0]  SPEC16         = 8'd16;
    localparam logic [7:0]  SPEC17         = 8'd17;
    localparam logic [31:0] MODE_WORD_INTR = 32'h0000_1000;
    localparam logic [31:0] MODE_WORD_NOIN = 32'h0000_2000;

    typedef enum logic [2:0] {
        OP_DELIVER   = 3'd0,
        OP_OPEN      = 3'd1,
        OP_CLOSE     = 3'd2,
        OP_WAIT      = 3'd3,
        OP_TEST      = 3'd4,
        OP_ENABLE    = 3'd5,
        OP_DISABLE   = 3'd6,
        OP_UNDELIVER = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_UNUSED  = 2'd0,
        ST_WAIT    = 2'd1,
        ST_ACTIVE  = 2'd2,
        ST_ALREADY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MC_OTHER  = 2'd0,
        MC_INTR   = 2'd1,
        MC_NOINTR = 2'd2
    } mode_class_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_MOD
    } back_state_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] event_class;
        logic [15:0] spec_mask;
        logic [31:0] mode_word;
        logic [31:0] handler_addr;
        logic [15:0] event_handle;
    } req_t;

    typedef struct packed {
        logic [15:0] return_value;
        logic        call_handler;
        logic [31:0] handler_out;
        logic        bad_index;
    } rsp_t;

    typedef struct packed {
        op_t                  op;
        logic [EV_W-1:0]      ev;
        logic [SPEC_W-1:0]    spec;
        logic                 bad;
        mode_class_t          mode_class;
        logic [HANDLER_W-1:0] handler;
    } cmd_t;

    typedef struct packed {
        status_t              status;
        mode_class_t          mode_class;
        logic [HANDLER_W-1:0] handler;
    } slot_t;

endpackage

[sv/ecbt_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module ecbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/ecbt_queue.sv]
// Two-entry command queue between the front and back parts.
`timescale 1ns / 1ps

module ecbt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ecbt_pkg::cmd_t push_cmd,
    input  logic          pop,
    output ecbt_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);
    import ecbt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == (PTR_W + 1)'(QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[sv/ecbt_front.sv]
// Front part: accepts request items and decodes them into slot commands.
`timescale 1ns / 1ps

module ecbt_front #(
    parameter int CLASS_GROUPS    = ecbt_pkg::CLASS_GROUPS_DEF,
    parameter int SLOTS_PER_CLASS = ecbt_pkg::SLOTS_PER_CLASS_DEF
) (
    input  logic           req_valid,
    output logic           req_ready,
    input  ecbt_pkg::req_t req,
    input  logic           queue_full,
    input  logic           clearing,
    output logic           push,
    output ecbt_pkg::cmd_t push_cmd
);
    import ecbt_pkg::*;

    localparam int ROWS = CLASS_GROUPS * CLASSES_PER_GROUP;

    logic [3:0]        grp;
    logic [EV_W-1:0]   ev;
    logic [SPEC_W-1:0] spec;
    logic [SPEC_W-1:0] mask_spec;
    logic              by_desc;

    assign req_ready = !queue_full && !clearing;
    assign push      = req_valid && req_ready;

    always_comb
    begin
        mask_spec = '0;
        if (req.spec_mask == MASK_SPEC16)
        begin
            mask_spec = SPEC16;
        end
        else if (req.spec_mask == MASK_SPEC17)
        begin
            mask_spec = SPEC17;
        end
        else
        begin
            for (int i = 15; i >= 0; i--)
            begin
                if (req.spec_mask[i])
                begin
                    mask_spec = SPEC_W'(i);
                end
            end
        end
    end

    always_comb
    begin
        grp     = (req.event_class[27:24] == GROUP_ALIAS) ? GROUP_ALIASED
                                                          : req.event_class[27:24];
        by_desc = (req.op inside {OP_DELIVER, OP_OPEN, OP_UNDELIVER});
        if (by_desc)
        begin
            ev   = {grp, req.event_class[4:0]};
            spec = mask_spec;
        end
        else
        begin
            ev   = {1'b0, req.event_handle[7:0]};
            spec = req.event_handle[15:8];
        end

        push_cmd.op      = op_t'(req.op);
        push_cmd.ev      = ev;
        push_cmd.spec    = spec;
        push_cmd.bad     = (32'(ev) >= ROWS) || (32'(spec) >= SLOTS_PER_CLASS);
        push_cmd.handler = req.handler_addr;
        if (req.mode_word == MODE_WORD_INTR)
        begin
            push_cmd.mode_class = MC_INTR;
        end
        else if (req.mode_word == MODE_WORD_NOIN)
        begin
            push_cmd.mode_class = MC_NOINTR;
        end
        else
        begin
            push_cmd.mode_class = MC_OTHER;
        end
    end

endmodule

[sv/ecbt_back.sv]
// Back part: clears the slot memory after reset and carries out one read-modify-write per item.
`timescale 1ns / 1ps

module ecbt_back #(
    parameter int CLASS_GROUPS    = ecbt_pkg::CLASS_GROUPS_DEF,
    parameter int SLOTS_PER_CLASS = ecbt_pkg::SLOTS_PER_CLASS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ecbt_pkg::cmd_t head,
    input  logic           queue_empty,
    output logic           pop,
    output logic           clearing,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output ecbt_pkg::rsp_t rsp
);
    import ecbt_pkg::*;

    localparam int DEPTH  = CLASS_GROUPS * CLASSES_PER_GROUP * SLOTS_PER_CLASS;
    localparam int ADDR_W = $clog2(DEPTH);

    back_state_t       state_reg;
    back_state_t       state_next;
    cmd_t              cmd_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [ADDR_W-1:0] clr_cnt_next;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;

    logic [31:0]       head_addr_full;
    logic [ADDR_W-1:0] head_addr;
    logic              out_free;
    logic              done;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [SLOT_W-1:0] ram_wdata;
    logic [SLOT_W-1:0] ram_rdata;
    slot_t             cur;
    slot_t             upd;
    rsp_t              result;

    assign head_addr_full = 32'(head.ev) * 32'(SLOTS_PER_CLASS) + 32'(head.spec);
    assign head_addr      = head_addr_full[ADDR_W-1:0];
    assign out_free       = !rsp_valid_reg || rsp_ready;
    assign cur            = slot_t'(ram_rdata);

    ecbt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (pop),
        .raddr (head_addr),
        .rdata (ram_rdata)
    );

    // Slot update and result for the command held in the modify cycle.
    always_comb
    begin
        upd                 = cur;
        result              = '0;
        result.bad_index    = cmd_reg.bad;
        case (cmd_reg.op)
            OP_DELIVER:
            begin
                if (cur.status == ST_ACTIVE)
                begin
                    if (cur.mode_class == MC_INTR)
                    begin
                        result.call_handler = 1'b1;
                        result.handler_out  = cur.handler;
                    end
                    else
                    begin
                        upd.status = ST_ALREADY;
                    end
                end
            end
            OP_OPEN:
            begin
                upd.status          = ST_WAIT;
                upd.mode_class      = cmd_reg.mode_class;
                upd.handler         = cmd_reg.handler;
                result.return_value = 16'(cmd_reg.ev) | {cmd_reg.spec, 8'h00};
            end
            OP_CLOSE:
            begin
                upd.status          = ST_UNUSED;
                result.return_value = 16'd1;
            end
            OP_WAIT, OP_ENABLE:
            begin
                upd.status          = ST_ACTIVE;
                result.return_value = 16'd1;
            end
            OP_TEST:
            begin
                if (cur.status == ST_ALREADY)
                begin
                    upd.status          = ST_ACTIVE;
                    result.return_value = 16'd1;
                end
            end
            OP_DISABLE:
            begin
                upd.status          = ST_WAIT;
                result.return_value = 16'd1;
            end
            OP_UNDELIVER:
            begin
                if (cur.status == ST_ALREADY && cur.mode_class == MC_NOINTR)
                begin
                    upd.status = ST_ACTIVE;
                end
            end
            default:
            begin
                upd = cur;
            end
        endcase
        if (cmd_reg.bad)
        begin
            result           = '0;
            result.bad_index = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!queue_empty)
                begin
                    state_next = B_MOD;
                end
            end
            B_MOD:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        clearing       = (state_reg == B_CLEAR);
        pop            = (state_reg == B_IDLE) && !queue_empty;
        done           = (state_reg == B_MOD) && out_free;
        ram_we         = clearing || (done && !cmd_reg.bad);
        ram_waddr      = clearing ? clr_cnt_reg : addr_reg;
        ram_wdata      = clearing ? '0 : SLOT_W'(upd);
        clr_cnt_next   = clearing ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
        rsp_next       = done ? result : rsp_reg;
        rsp_valid_next = done ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg  <= head;
            addr_reg <= head_addr;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A popped command always reaches the modify cycle next.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == B_MOD))
        else $error("popped command did not enter the modify cycle");

    // An out-of-table command never writes the slot memory.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && !clearing) |-> !cmd_reg.bad)
        else $error("slot memory written for an out-of-table command");

    // A finished item always shows up as a valid result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> rsp_valid_reg)
        else $error("finished item did not produce a result");

    // No command leaves the queue while the clearing pass runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLEAR) |-> !pop && !rsp_valid_next)
        else $error("command handled during the clearing pass");

endmodule

[sv/event_control_block_table.sv]
// Top level of the event control block table: front decoder, command queue and slot engine.
//
//   Channel  | Signals                    | Direction | Payload
//   ---------+----------------------------+-----------+---------------------------
//   req      | req_valid, req_ready, req  | in        | op, class, mask, mode, handle
//   rsp      | rsp_valid, rsp_ready, rsp  | out       | return value, handler, flags
//
// The slot engine handles one item at a time: it reads the slot memory in the idle state,
// then computes and writes back the slot in the modify state, which waits for a free result.
// After reset a clearing pass writes every slot to unused, one slot per cycle, across all
// CLASS_GROUPS * 32 * SLOTS_PER_CLASS slots (6144 by default); req_ready stays low meanwhile.
// A two-entry queue and the result register let the request side keep going while a result waits.
`timescale 1ns / 1ps

module event_control_block_table #(
    parameter int CLASS_GROUPS    = ecbt_pkg::CLASS_GROUPS_DEF,
    parameter int SLOTS_PER_CLASS = ecbt_pkg::SLOTS_PER_CLASS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  ecbt_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output ecbt_pkg::rsp_t rsp
);
    import ecbt_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic pop;
    cmd_t head;
    logic queue_empty;
    logic queue_full;
    logic clearing;

    ecbt_front #(
        .CLASS_GROUPS    (CLASS_GROUPS),
        .SLOTS_PER_CLASS (SLOTS_PER_CLASS)
    ) u_front (
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .queue_full (queue_full),
        .clearing   (clearing),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    ecbt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    ecbt_back #(
        .CLASS_GROUPS    (CLASS_GROUPS),
        .SLOTS_PER_CLASS (SLOTS_PER_CLASS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .queue_empty (queue_empty),
        .pop         (pop),
        .clearing    (clearing),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

endmodule

[dv/ecbt_slot_monitor.sv]
// Monitor that models the event slot table, predicts every result and compares it.
`timescale 1ns / 1ps

module ecbt_slot_monitor (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_ready,
    input  ecbt_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_ready,
    input  ecbt_pkg::rsp_t rsp,
    output int             fail_count,
    output int             in_flight,
    output int             results_checked,
    output int             handler_calls
);

    import ecbt_pkg::*;

    localparam int ROWS  = CLASS_GROUPS_DEF * CLASSES_PER_GROUP;
    localparam int DEPTH = ROWS * SLOTS_PER_CLASS_DEF;

    status_t     slot_status  [DEPTH];
    mode_class_t slot_mode    [DEPTH];
    logic [31:0] slot_handler [DEPTH];
    rsp_t        awaited_results[$];
    int          errors = 0;
    int          checked = 0;
    int          calls = 0;

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_status[i]  = ST_UNUSED;
            slot_mode[i]    = MC_OTHER;
            slot_handler[i] = '0;
        end
    end

    function automatic rsp_t apply_to_table(req_t r);
        rsp_t       res;
        op_t        op;
        logic [3:0] grp;
        int         ev;
        int         spec;
        int         slot;
        res = '0;
        op  = op_t'(r.op);
        if (op inside {OP_DELIVER, OP_OPEN, OP_UNDELIVER})
        begin
            grp = (r.event_class[27:24] == GROUP_ALIAS) ? GROUP_ALIASED : r.event_class[27:24];
            ev  = grp * CLASSES_PER_GROUP + r.event_class[4:0];
            if (r.spec_mask == MASK_SPEC16)
                spec = int'(SPEC16);
            else if (r.spec_mask == MASK_SPEC17)
                spec = int'(SPEC17);
            else
            begin
                spec = 0;
                for (int b = 15; b >= 0; b--)
                    if (r.spec_mask[b])
                        spec = b;
            end
        end
        else
        begin
            ev   = int'(r.event_handle[7:0]);
            spec = int'(r.event_handle[15:8]);
        end

        if (ev >= ROWS || spec >= SLOTS_PER_CLASS_DEF)
        begin
            res.bad_index = 1'b1;
            return res;
        end
        slot = ev * SLOTS_PER_CLASS_DEF + spec;

        case (op)
            OP_DELIVER:
            begin
                if (slot_status[slot] == ST_ACTIVE)
                begin
                    if (slot_mode[slot] == MC_INTR)
                    begin
                        res.call_handler = 1'b1;
                        res.handler_out  = slot_handler[slot];
                    end
                    else
                        slot_status[slot] = ST_ALREADY;
                end
            end
            OP_OPEN:
            begin
                slot_status[slot]  = ST_WAIT;
                slot_mode[slot]    = (r.mode_word == MODE_WORD_INTR) ? MC_INTR :
                                     (r.mode_word == MODE_WORD_NOIN) ? MC_NOINTR : MC_OTHER;
                slot_handler[slot] = r.handler_addr;
                res.return_value   = 16'(ev | (spec << 8));
            end
            OP_CLOSE:
            begin
                slot_status[slot] = ST_UNUSED;
                res.return_value  = 16'd1;
            end
            OP_WAIT, OP_ENABLE:
            begin
                slot_status[slot] = ST_ACTIVE;
                res.return_value  = 16'd1;
            end
            OP_TEST:
            begin
                if (slot_status[slot] == ST_ALREADY)
                begin
                    slot_status[slot] = ST_ACTIVE;
                    res.return_value  = 16'd1;
                end
            end
            OP_DISABLE:
            begin
                slot_status[slot] = ST_WAIT;
                res.return_value  = 16'd1;
            end
            default:
            begin
                if (slot_status[slot] == ST_ALREADY && slot_mode[slot] == MC_NOINTR)
                    slot_status[slot] = ST_ACTIVE;
            end
        endcase
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, rsp);
                    errors++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("return_value", 32'(want.return_value),
                                32'(rsp.return_value));
                    check_field("call_handler", 32'(want.call_handler),
                                32'(rsp.call_handler));
                    check_field("handler_out", want.handler_out, rsp.handler_out);
                    check_field("bad_index", 32'(want.bad_index), 32'(rsp.bad_index));
                    checked++;
                    if (want.call_handler)
                        calls++;
                end
            end
            if (req_valid && req_ready)
                awaited_results.push_back(apply_to_table(req));
        end
        fail_count      <= errors;
        in_flight       <= awaited_results.size();
        results_checked <= checked;
        handler_calls   <= calls;
    end

endmodule

[dv/tb_event_control_block_table.sv]
// Testbench top for the event control block table: stimulus, receiver pacing and verdict.
`timescale 1ns / 1ps

module tb_event_control_block_table;

    import ecbt_pkg::*;

    localparam int PHASE_ITEMS = 560;
    localparam int LONG_HOLD   = 300;
    localparam int POOL_SIZE   = 6;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    int fail_count;
    int in_flight;
    int results_checked;
    int handler_calls;
    int send_idle_pct = 0;
    int take_idle_pct = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int items_sent = 0;
    int directed_items = 0;

    int pool_ev   [POOL_SIZE];
    int pool_spec [POOL_SIZE];

    event_control_block_table uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    ecbt_slot_monitor monitor (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .fail_count(fail_count),
        .in_flight(in_flight),
        .results_checked(results_checked),
        .handler_calls(handler_calls)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("event_control_block_table verification failed");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (holds_served != holds_asked)
            begin
                holds_served++;
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
                rsp_ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    task automatic offer(input req_t item);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        items_sent++;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
    endtask

    task automatic refresh_pool();
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            pool_ev[k]   = $urandom_range(191);
            pool_spec[k] = (k == POOL_SIZE - 1) ? $urandom_range(31, 18) : $urandom_range(17);
        end
    endtask

    function automatic req_t compose(op_t op, logic [31:0] cls, logic [15:0] mask,
                                     logic [31:0] mode, logic [31:0] hand,
                                     logic [15:0] handle);
        req_t r;
        r.op           = op;
        r.event_class  = cls;
        r.spec_mask    = mask;
        r.mode_word    = mode;
        r.handler_addr = hand;
        r.event_handle = handle;
        return r;
    endfunction

    function automatic logic [31:0] class_word(int ev);
        logic [31:0] w;
        logic [3:0]  grp;
        w   = $urandom;
        grp = 4'(ev / CLASSES_PER_GROUP);
        if (grp == GROUP_ALIASED && $urandom_range(1) == 1)
            grp = GROUP_ALIAS;
        w[27:24] = grp;
        w[4:0]   = 5'(ev % CLASSES_PER_GROUP);
        return w;
    endfunction

    function automatic logic [15:0] mask_word(int spec);
        logic [15:0] upper;
        logic [15:0] one;
        upper = 16'($urandom);
        one   = 16'h0001;
        if (spec == SPEC16)
            return MASK_SPEC16;
        if (spec == SPEC17)
            return MASK_SPEC17;
        if (spec > SPEC17)
            return upper;
        if (spec == 0 && $urandom_range(3) == 0)
            return 16'h0000;
        return (upper << (spec + 1)) | (one << spec);
    endfunction

    function automatic req_t random_request();
        req_t r;
        int   k;
        int   pick;
        int   ev;
        int   spec;
        r.op           = 3'($urandom);
        r.event_class  = $urandom;
        r.spec_mask    = 16'($urandom);
        r.mode_word    = $urandom;
        r.handler_addr = $urandom;
        r.event_handle = 16'($urandom);
        if ($urandom_range(99) < 12)
            return r;

        k    = $urandom_range(POOL_SIZE - 1);
        ev   = pool_ev[k];
        spec = pool_spec[k];
        pick = $urandom_range(99);
        if (pick < 15)
            r.op = OP_OPEN;
        else if (pick < 35)
            r.op = OP_ENABLE;
        else if (pick < 45)
            r.op = OP_WAIT;
        else if (pick < 70)
            r.op = OP_DELIVER;
        else if (pick < 82)
            r.op = OP_TEST;
        else if (pick < 92)
            r.op = OP_UNDELIVER;
        else if (pick < 96)
            r.op = OP_DISABLE;
        else
            r.op = OP_CLOSE;
        r.event_class  = class_word(ev);
        r.spec_mask    = mask_word(spec);
        r.event_handle = {spec[7:0], ev[7:0]};
        pick = $urandom_range(99);
        if (pick < 45)
            r.mode_word = MODE_WORD_INTR;
        else if (pick < 80)
            r.mode_word = MODE_WORD_NOIN;
        return r;
    endfunction

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        offer(compose(OP_OPEN,      32'h0000_0000, 16'h0000, MODE_WORD_INTR, 32'hffff_ffff,
                      16'h0000));
        offer(compose(OP_DELIVER,   32'h0000_0000, 16'h0001, 32'h0, 32'h0, 16'h0000));
        offer(compose(OP_ENABLE,    32'h0000_0000, 16'h0000, 32'h0, 32'h0, 16'h0000));
        offer(compose(OP_DELIVER,   32'h0000_0000, 16'h0001, 32'h0, 32'h0, 16'h0000));
        offer(compose(OP_UNDELIVER, 32'h0000_0000, 16'h0000, 32'h0, 32'h0, 16'h0000));
        offer(compose(OP_DISABLE,   32'h0000_0000, 16'h0000, 32'h0, 32'h0, 16'h0000));
        offer(compose(OP_OPEN,      32'h0f00_001f, 16'h8000, MODE_WORD_NOIN, 32'h0,
                      16'h0000));
        offer(compose(OP_WAIT,      32'h0, 16'h0, 32'h0, 32'h0, 16'h0fbf));
        offer(compose(OP_DELIVER,   32'h0500_001f, 16'h8000, 32'h0, 32'h0, 16'h0000));
        offer(compose(OP_TEST,      32'h0, 16'h0, 32'h0, 32'h0, 16'h0fbf));
        offer(compose(OP_DELIVER,   32'hffff_ffff, 16'h8000, 32'h0, 32'h0, 16'h0000));
        offer(compose(OP_UNDELIVER, 32'h0f00_001f, 16'h8000, 32'h0, 32'h0, 16'h0000));
        offer(compose(OP_TEST,      32'h0, 16'h0, 32'h0, 32'h0, 16'h0fbf));
        offer(compose(OP_OPEN,      32'h0100_0005, MASK_SPEC16, 32'h0000_4000, 32'ha5a5_5a5a,
                      16'h0000));
        offer(compose(OP_ENABLE,    32'h0, 16'h0, 32'h0, 32'h0, 16'h1025));
        offer(compose(OP_DELIVER,   32'h0100_0005, MASK_SPEC16, 32'h0, 32'h0, 16'h0000));
        offer(compose(OP_UNDELIVER, 32'h0100_0005, MASK_SPEC16, 32'h0, 32'h0, 16'h0000));
        offer(compose(OP_TEST,      32'h0, 16'h0, 32'h0, 32'h0, 16'h1025));
        offer(compose(OP_OPEN,      32'h0000_0002, MASK_SPEC17, 32'h0, 32'h0, 16'h0000));
        offer(compose(OP_CLOSE,     32'h0, 16'h0, 32'h0, 32'h0, 16'h1102));
        offer(compose(OP_OPEN,      32'h0e00_001f, 16'h0004, MODE_WORD_INTR, 32'h1,
                      16'h0000));
        offer(compose(OP_CLOSE,     32'h0, 16'h0, 32'h0, 32'h0, 16'h2000));
        offer(compose(OP_ENABLE,    32'h0, 16'h0, 32'h0, 32'h0, 16'h00c0));
        offer(compose(OP_DISABLE,   32'h0, 16'h0, 32'h0, 32'h0, 16'hffff));
        offer(compose(OP_ENABLE,    32'h0, 16'h0, 32'h0, 32'h0, 16'h1fbf));
        directed_items = items_sent;
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 70 : 0;
            take_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 13 : 0;
            refresh_pool();
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (phase == 2 && i == 100)
                    holds_asked++;
                offer(random_request());
            end
            drain();
        end

        repeat (20) @(posedge clk);
        $display("Sent %0d requests (%0d directed) under three idle mixes and a %0d-cycle stall.",
                 items_sent, directed_items, LONG_HOLD);
        $display("Compared %0d results, %0d of which asked for a handler call.",
                 results_checked, handler_calls);
        if (fail_count == 0 && in_flight == 0)
            $display("event_control_block_table verification clean");
        else
            $display("event_control_block_table verification failed");
        $finish;
    end

endmodule
